FILE: hw/rtl/bfr_pkg.sv
`timescale 1ns / 1ps
// bfr_pkg: shared constants, codes and types of the byte stuffed frame receiver.
// No dependencies.
package bfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] XOR_MASK  = 8'h20;

    localparam logic [1:0] MIN_RAW = 2'd3;
    localparam logic [1:0] RAW_SAT = 2'd3;

    localparam int          IDLE_W   = 17;
    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    localparam int          TMO_W     = 16;
    localparam logic [15:0] TMO_RESET = 16'd1000;

    // APB map: one 32-bit register per word
    localparam int          PADDR_W     = 3;
    localparam int          PDATA_W     = 32;
    localparam logic [0:0]  REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_SHORT = 2'd1,
        STS_ESC   = 2'd2,
        STS_OVF   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERR,
        S_RD,
        S_WT
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_store_rd;

endpackage

FILE: hw/rtl/bfr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: raw input items and payload result items.
// Depends on nothing.
interface bfr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface bfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output payload_byte, output last, output status,
                    input ready);
    modport sink   (input valid, input payload_byte, input last, input status,
                    output ready);
endinterface

FILE: hw/rtl/bfr_store.sv
`timescale 1ns / 1ps
// bfr_store: payload byte memory, one write and one read port, registered read.
// Depends on bfr_pkg.
module bfr_store (
    input  logic                     i_clk,
    input  bfr_pkg::t_store_wr       i_wr,
    input  bfr_pkg::t_store_rd       i_rd,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_mem [bfr_pkg::BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/bfr_cfg.sv
`timescale 1ns / 1ps
// bfr_cfg: APB register block holding the frame timeout.
// Depends on bfr_pkg.
module bfr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfr_pkg::PADDR_W-1:0]       paddr,
    input  logic [bfr_pkg::PDATA_W-1:0]       pwdata,
    output logic [bfr_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    output logic [bfr_pkg::TMO_W-1:0]         o_timeout
);

    logic [bfr_pkg::TMO_W-1:0] r_timeout;
    logic [bfr_pkg::TMO_W-1:0] n_timeout;
    logic                      w_sel_tmo;

    assign w_sel_tmo = (paddr[2] == bfr_pkg::REG_TIMEOUT);
    assign pready    = 1'b1;

    always_comb begin
        n_timeout = r_timeout;
        if (psel && penable && pwrite && w_sel_tmo) begin
            n_timeout = pwdata[bfr_pkg::TMO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= bfr_pkg::TMO_RESET;
        end else begin
            r_timeout <= n_timeout;
        end
    end

    assign prdata    = w_sel_tmo ?
                       {{(bfr_pkg::PDATA_W - bfr_pkg::TMO_W){1'b0}}, r_timeout} :
                       {bfr_pkg::PDATA_W{1'b0}};
    assign o_timeout = r_timeout;

endmodule

FILE: hw/rtl/byte_stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// Top level: byte stuffed frame receiver (flag/escape unstuffing, frame drain).
// Depends on bfr_pkg, bfr_if, bfr_store, bfr_cfg.
//
//   port      | dir | handshake            | payload
//   ----------+-----+----------------------+-----------------------------------
//   i_in      | in  | valid / ready        | func, rx_byte
//   o_out     | out | valid / ready        | payload_byte, last, status
//   APB       | in  | psel, penable, pready| paddr, pwdata, prdata (timeout reg)
//
// Steps: a tick, a non-flag byte or a flag closing an empty frame is taken in
// S_IDLE alone. A flag closing a bad frame goes on to S_ERR to load the error
// item. A flag closing a good frame visits S_RD and then S_WT per payload byte
// (address the store, then load its registered read data); input ready is low
// meanwhile. Reset is synchronous, active low; the store needs no clearing pass.
// A stalled output stretches S_ERR and S_WT, and only those.
module byte_stuffed_frame_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bfr_in_if.sink                            i_in,
    bfr_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfr_pkg::PADDR_W-1:0]       paddr,
    input  logic [bfr_pkg::PDATA_W-1:0]       pwdata,
    output logic [bfr_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int CW = bfr_pkg::CNT_W;
    localparam int AW = bfr_pkg::ADDR_W;

    // ---------------------------------------------------------------- config
    logic [bfr_pkg::TMO_W-1:0] w_timeout;

    bfr_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (w_timeout)
    );

    // ---------------------------------------------------------------- state
    bfr_pkg::t_state  r_state, n_state;

    // frame being collected
    logic [CW-1:0]                r_count, n_count;
    logic [1:0]                   r_raw, n_raw;
    logic                         r_esc, n_esc;
    logic                         r_ovf, n_ovf;
    logic [bfr_pkg::IDLE_W-1:0]   r_idle, n_idle;

    // closed frame being drained / reported
    logic [CW-1:0]                r_drain_len, n_drain_len;
    logic [CW-1:0]                r_rd_cnt, n_rd_cnt;
    bfr_pkg::t_status             r_err_sts, n_err_sts;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [7:0]                   r_out_byte, n_out_byte;
    logic                         r_out_last, n_out_last;
    logic [1:0]                   r_out_sts, n_out_sts;

    // ---------------------------------------------------------------- store
    bfr_pkg::t_store_wr w_wr;
    bfr_pkg::t_store_rd w_rd;
    logic [7:0]         w_rd_data;

    bfr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // ---------------------------------------------------------------- decode
    logic             w_in_acc;
    logic             w_is_byte;
    logic             w_is_flag;
    logic             w_flag_err;
    logic             w_flag_drain;
    logic             w_out_free;
    logic [CW-1:0]    w_rd_next;
    logic             w_rd_last;
    bfr_pkg::t_status w_err_code;
    logic             w_out_load;
    logic [7:0]       w_out_byte;
    logic             w_out_last;
    logic [1:0]       w_out_sts;

    assign i_in.ready = (r_state == bfr_pkg::S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_is_byte  = w_in_acc && !i_in.func;
    assign w_is_flag  = w_is_byte && (i_in.rx_byte == bfr_pkg::FLAG_BYTE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // flag verdict; short beats overflow beats dangling escape
    assign w_flag_err   = (r_raw != 2'd0) &&
                          ((r_raw < bfr_pkg::MIN_RAW) || r_ovf || r_esc);
    assign w_flag_drain = (r_raw >= bfr_pkg::MIN_RAW) && !r_ovf && !r_esc &&
                          (r_count != '0);

    always_comb begin
        if (r_raw < bfr_pkg::MIN_RAW) begin
            w_err_code = bfr_pkg::STS_SHORT;
        end else if (r_ovf) begin
            w_err_code = bfr_pkg::STS_OVF;
        end else begin
            w_err_code = bfr_pkg::STS_ESC;
        end
    end

    assign w_rd_next = r_rd_cnt + CW'(1);
    assign w_rd_last = (w_rd_next == r_drain_len);

    // ---------------------------------------------------------------- FSM next
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfr_pkg::S_IDLE: begin
                if (w_is_flag && w_flag_err) begin
                    n_state = bfr_pkg::S_ERR;
                end else if (w_is_flag && w_flag_drain) begin
                    n_state = bfr_pkg::S_RD;
                end
            end
            bfr_pkg::S_ERR: begin
                if (w_out_free) begin
                    n_state = bfr_pkg::S_IDLE;
                end
            end
            bfr_pkg::S_RD: begin
                n_state = bfr_pkg::S_WT;
            end
            bfr_pkg::S_WT: begin
                if (w_out_free) begin
                    n_state = w_rd_last ? bfr_pkg::S_IDLE : bfr_pkg::S_RD;
                end
            end
            default: begin
                n_state = bfr_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- FSM outputs
    always_comb begin
        w_rd.en    = 1'b0;
        w_rd.addr  = r_rd_cnt[AW-1:0];
        w_out_load = 1'b0;
        w_out_byte = 8'h00;
        w_out_last = 1'b1;
        w_out_sts  = bfr_pkg::STS_OK;
        case (r_state)
            bfr_pkg::S_ERR: begin
                w_out_load = w_out_free;
                w_out_sts  = r_err_sts;
            end
            bfr_pkg::S_RD: begin
                w_rd.en = 1'b1;
            end
            bfr_pkg::S_WT: begin
                w_out_load = w_out_free;
                w_out_byte = w_rd_data;
                w_out_last = w_rd_last;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        n_count     = r_count;
        n_raw       = r_raw;
        n_esc       = r_esc;
        n_ovf       = r_ovf;
        n_idle      = r_idle;
        n_drain_len = r_drain_len;
        n_rd_cnt    = r_rd_cnt;
        n_err_sts   = r_err_sts;
        w_wr.en     = 1'b0;
        w_wr.addr   = r_count[AW-1:0];
        w_wr.data   = i_in.rx_byte;

        if (w_in_acc && i_in.func) begin
            // millisecond tick, saturating
            if (r_idle < bfr_pkg::IDLE_MAX) begin
                n_idle = r_idle + bfr_pkg::IDLE_W'(1);
            end
        end else if (w_is_flag) begin
            // close the frame: latch what the drain or error report needs
            n_idle      = '0;
            n_drain_len = r_count;
            n_rd_cnt    = '0;
            n_err_sts   = w_err_code;
            n_count     = '0;
            n_raw       = 2'd0;
            n_esc       = 1'b0;
            n_ovf       = 1'b0;
        end else if (w_is_byte) begin
            if (r_idle > bfr_pkg::IDLE_W'(w_timeout)) begin
                // stale partial frame; idle count keeps running until a flag
                n_count = '0;
                n_raw   = 2'd0;
                n_esc   = 1'b0;
                n_ovf   = 1'b0;
            end else begin
                if (r_raw < bfr_pkg::RAW_SAT) begin
                    n_raw = r_raw + 2'd1;
                end
                if (i_in.rx_byte == bfr_pkg::ESC_BYTE) begin
                    n_esc = 1'b1;
                end else begin
                    n_esc     = 1'b0;
                    w_wr.data = r_esc ? (i_in.rx_byte ^ bfr_pkg::XOR_MASK) : i_in.rx_byte;
                    if (r_count < CW'(bfr_pkg::BUFFER_DEPTH)) begin
                        w_wr.en = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
        end

        // drain address steps when a read byte moves to the output register
        if ((r_state == bfr_pkg::S_WT) && w_out_free) begin
            n_rd_cnt = w_rd_next;
        end
    end

    // output register: loads when free, else drops once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_sts   = r_out_sts;
        if (w_out_load) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_out_byte;
            n_out_last  = w_out_last;
            n_out_sts   = w_out_sts;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfr_pkg::S_IDLE;
            r_count     <= '0;
            r_raw       <= 2'd0;
            r_esc       <= 1'b0;
            r_ovf       <= 1'b0;
            r_idle      <= '0;
            r_drain_len <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_raw       <= n_raw;
            r_esc       <= n_esc;
            r_ovf       <= n_ovf;
            r_idle      <= n_idle;
            r_drain_len <= n_drain_len;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err_sts  <= n_err_sts;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_sts  <= n_out_sts;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.last         = r_out_last;
    assign o_out.status       = r_out_sts;

endmodule

FILE: bench/byte_stuffed_frame_receiver_test.sv
`timescale 1ns / 1ps
// Testbench for byte_stuffed_frame_receiver: flag/escape unstuffing, frame status and timeout.
// Depends on bfr_pkg, bfr_if and the RTL top; runs stand-alone with a built-in predictor.
module byte_stuffed_frame_receiver_test;

    // item kinds on the input channel
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

    localparam logic [bfr_pkg::PADDR_W-1:0] TMO_ADDR    = {bfr_pkg::REG_TIMEOUT, 2'b00};
    localparam logic [bfr_pkg::PADDR_W-1:0] UNUSED_ADDR = 3'd4;   // register index 1, not mapped

    localparam int SETTLE_CYCLES = 8;      // a byte or a tick may still be in flight
    localparam int END_CYCLES    = 32;
    localparam int STALL_LIMIT   = 4000;   // cycles with no item moving on either side

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             last;
        bfr_pkg::t_status status;
    } t_payload_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bfr_pkg::PADDR_W-1:0]   paddr;
    logic [bfr_pkg::PDATA_W-1:0]   pwdata;
    logic [bfr_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    bfr_in_if  rx_link ();
    bfr_out_if payload_out ();

    byte_stuffed_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_link),
        .o_out   (payload_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor state: a private copy of what the deframer keeps per frame.
    // ---------------------------------------------------------------------
    logic [7:0]                  rx_store [bfr_pkg::BUFFER_DEPTH];
    int                          rx_count;
    logic [1:0]                  raw_seen;        // raw bytes since last flag, saturates
    logic                        esc_armed;
    logic                        store_overflow;
    logic [bfr_pkg::IDLE_W-1:0]  idle_cnt;
    logic [bfr_pkg::TMO_W-1:0]   timeout_ms;

    t_payload_item      payload_q [$];   // results still owed by the block

    int src_idle_pct;
    int sink_idle_pct;
    int items_sent;
    int fail_count;
    int stall_cycles = 0;

    function automatic void clear_frame_state();
        rx_count       = 0;
        raw_seen       = '0;
        esc_armed      = 1'b0;
        store_overflow = 1'b0;
    endfunction

    // Append one result item to the owed list.
    function automatic void owe_result(input t_payload_item item);
        payload_q = {payload_q, item};
    endfunction

    // Work out the result items that one accepted input item causes.
    function automatic void predict_payload(input logic func, input logic [7:0] b);
        logic [7:0] d;
        d = b;
        if (func == ITEM_TICK) begin
            if (idle_cnt != bfr_pkg::IDLE_MAX)
                idle_cnt++;
            return;
        end
        if (b == bfr_pkg::FLAG_BYTE) begin
            idle_cnt = '0;
            // empty frame gives nothing; short beats overflow beats open escape
            if (raw_seen != '0) begin
                if (raw_seen < bfr_pkg::MIN_RAW)
                    owe_result('{8'h00, 1'b1, bfr_pkg::STS_SHORT});
                else if (store_overflow)
                    owe_result('{8'h00, 1'b1, bfr_pkg::STS_OVF});
                else if (esc_armed)
                    owe_result('{8'h00, 1'b1, bfr_pkg::STS_ESC});
                else
                    for (int i = 0; i < rx_count; i++)
                        owe_result('{rx_store[i], (i == rx_count - 1), bfr_pkg::STS_OK});
            end
            clear_frame_state();
            return;
        end
        // stale partial frame: dropped, and the idle count keeps running
        if (idle_cnt > {1'b0, timeout_ms}) begin
            clear_frame_state();
            return;
        end
        if (raw_seen != bfr_pkg::RAW_SAT)
            raw_seen++;
        if (b == bfr_pkg::ESC_BYTE) begin
            esc_armed = 1'b1;     // a second escape just stays pending
            return;
        end
        if (esc_armed) begin
            d = b ^ bfr_pkg::XOR_MASK;
            esc_armed = 1'b0;
        end
        if (rx_count < bfr_pkg::BUFFER_DEPTH) begin
            rx_store[rx_count] = d;
            rx_count++;
        end else begin
            store_overflow = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result checker: every accepted output item against the oldest one owed.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_payload_item want;
        if (i_rst_n && payload_out.valid && payload_out.ready) begin
            if (payload_q.size() == 0) begin
                $error("unexpected result item: payload_byte %0h last %0b status %0d",
                       payload_out.payload_byte, payload_out.last, payload_out.status);
                fail_count++;
            end else begin
                want = payload_q.pop_front();
                if (payload_out.payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, payload_out.payload_byte);
                    fail_count++;
                end
                if (payload_out.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, payload_out.last);
                    fail_count++;
                end
                if (payload_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, payload_out.status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver side: random back-pressure at the current idle rate.
    always @(posedge i_clk)
        payload_out.ready <= ($urandom_range(99) >= sink_idle_pct);

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge i_clk) begin
        if ((rx_link.valid && rx_link.ready) || (payload_out.valid && payload_out.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // One input item. valid is left high after the handshake so back-to-back
    // items never lower and raise it in the same step; gaps lower it first.
    task automatic send_item(input logic func, input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            rx_link.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge i_clk);
        end
        rx_link.valid   <= 1'b1;
        rx_link.func    <= func;
        rx_link.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_link.ready)
            @(posedge i_clk);
        predict_payload(func, b);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ITEM_BYTE, b);
    endtask

    // rx_byte carries junk on ticks; the block must ignore it
    task automatic send_tick();
        send_item(ITEM_TICK, 8'($urandom_range(255)));
    endtask

    // Stuff a payload byte the way a transmitter would.
    task automatic send_payload_byte(input logic [7:0] b, input logic force_esc);
        if (force_esc || b == bfr_pkg::FLAG_BYTE || b == bfr_pkg::ESC_BYTE) begin
            send_byte(bfr_pkg::ESC_BYTE);
            send_byte(b ^ bfr_pkg::XOR_MASK);
        end else begin
            send_byte(b);
        end
    endtask

    // Hold the input off until every owed result has come, then let the
    // block finish anything that produces no result.
    task automatic wait_all_results();
        rx_link.valid <= 1'b0;
        @(posedge i_clk);
        while (payload_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [bfr_pkg::PADDR_W-1:0] addr,
                                  input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};   // upper bits are don't-care
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == TMO_ADDR)
            timeout_ms = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Empty frames, too-short frames, a minimal good frame, open escape.
    task automatic test_frame_status_codes();
        send_byte(bfr_pkg::FLAG_BYTE);                 // empty: nothing
        send_byte(bfr_pkg::FLAG_BYTE);
        send_byte(8'h00);
        send_byte(bfr_pkg::FLAG_BYTE);                 // one raw byte: too short
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(bfr_pkg::FLAG_BYTE);                 // two raw bytes: too short
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(bfr_pkg::FLAG_BYTE);                 // three bytes: good
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(bfr_pkg::FLAG_BYTE);                 // short wins over open escape
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(bfr_pkg::FLAG_BYTE);                 // unterminated escape
        send_tick();
        send_byte(bfr_pkg::FLAG_BYTE);
    endtask

    // Escaped flag, escaped escape, double escape, XOR to both extremes.
    task automatic test_escape_handling();
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(8'h5E);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(8'h5D);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(8'h41);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(8'h20);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(8'hDF);
        send_byte(8'h7F);
        send_byte(bfr_pkg::FLAG_BYTE);
    endtask

    // Full store, then one byte past it together with an open escape.
    task automatic test_buffer_limits();
        repeat (bfr_pkg::BUFFER_DEPTH) send_payload_byte(8'($urandom_range(255)), 1'b0);
        send_byte(bfr_pkg::FLAG_BYTE);
        repeat (bfr_pkg::BUFFER_DEPTH + 1) send_payload_byte(8'($urandom_range(255)), 1'b0);
        send_byte(bfr_pkg::ESC_BYTE);
        send_byte(bfr_pkg::FLAG_BYTE);
    endtask

    // Timeout at 3: exactly 3 idle ticks still accepted, 4 drop the frame.
    task automatic test_timeout_boundary();
        send_byte(bfr_pkg::FLAG_BYTE);
        repeat (3) send_tick();
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_byte(bfr_pkg::FLAG_BYTE);                 // good frame
        repeat (4) send_tick();
        send_byte(8'h01);                              // stale: dropped
        send_tick();
        send_byte(8'h02);                              // still stale
        send_byte(bfr_pkg::FLAG_BYTE);                 // nothing left
        send_byte(8'h10);
        send_byte(8'h20);
        repeat (4) send_tick();
        send_byte(8'h30);                              // clears the partial frame
        send_byte(bfr_pkg::FLAG_BYTE);
    endtask

    // Timeout at 0: any tick since the flag kills the frame.
    task automatic test_zero_timeout();
        send_byte(bfr_pkg::FLAG_BYTE);
        send_byte(8'hC3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bfr_pkg::FLAG_BYTE);                 // good frame
        send_byte(8'h55);
        send_tick();
        send_byte(8'hAA);                              // clears 0x55 too
        send_byte(8'h66);
        send_byte(bfr_pkg::FLAG_BYTE);
    endtask

    // Timeout at its maximum: a few idle ticks leave the frame intact.
    task automatic test_max_timeout();
        send_byte(bfr_pkg::FLAG_BYTE);
        repeat (6) send_tick();
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(bfr_pkg::FLAG_BYTE);                 // good frame
    endtask

    // Mostly well-formed stuffed frames with random content; some noise,
    // short frames, dangling escapes and idle ticks in between.
    task automatic test_random_traffic(input int n_items, input int tick_span);
        int first;
        int len;
        int pick;
        logic [7:0] b;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                wait_all_results();
            end else if (pick < 12) begin
                repeat ($urandom_range(4, 1))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end else if (pick < 20) begin
                repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
                send_byte(bfr_pkg::FLAG_BYTE);
            end else begin
                repeat ($urandom_range(tick_span)) send_tick();
                pick = $urandom_range(99);
                if (pick < 90)
                    len = $urandom_range(12, 3);
                else if (pick < 97)
                    len = $urandom_range(40, 13);
                else
                    len = $urandom_range(70, 60);
                repeat (len) begin
                    if ($urandom_range(99) < 3)
                        send_tick();
                    if ($urandom_range(99) < 10)
                        b = $urandom_range(1) ? bfr_pkg::FLAG_BYTE : bfr_pkg::ESC_BYTE;
                    else
                        b = 8'($urandom_range(255));
                    send_payload_byte(b, $urandom_range(99) < 5);
                end
                if ($urandom_range(99) < 5)
                    send_byte(bfr_pkg::ESC_BYTE);
                send_byte(bfr_pkg::FLAG_BYTE);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        rx_link.valid       = 1'b0;
        rx_link.func        = ITEM_BYTE;
        rx_link.rx_byte     = 8'h00;
        payload_out.ready   = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        src_idle_pct        = 13;
        sink_idle_pct       = 68;
        items_sent          = 0;
        fail_count          = 0;
        clear_frame_state();
        idle_cnt            = '0;
        timeout_ms          = bfr_pkg::TMO_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver mostly stalled; reset timeout
        test_frame_status_codes();
        test_escape_handling();
        test_buffer_limits();
        wait_all_results();

        // sender mostly idle, receiver mostly ready; short timeout
        src_idle_pct  = 68;
        sink_idle_pct = 13;
        write_register(TMO_ADDR, 16'd3);
        write_register(UNUSED_ADDR, 16'($urandom));   // must not touch the timeout
        test_timeout_boundary();
        test_random_traffic(10, 5);
        wait_all_results();

        // no idling; timeout extremes
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_register(TMO_ADDR, 16'd0);
        test_zero_timeout();
        wait_all_results();
        write_register(TMO_ADDR, 16'hFFFF);
        test_max_timeout();
        test_random_traffic(10, 2);
        wait_all_results();

        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bfr_pkg.sv
hw/rtl/bfr_if.sv
hw/rtl/bfr_store.sv
hw/rtl/bfr_cfg.sv
hw/rtl/byte_stuffed_frame_receiver.sv
bench/byte_stuffed_frame_receiver_test.sv
